[design/ptw_pkg.sv]
`timescale 1ns / 1ps

package ptw_pkg;

    localparam int WINDOW_WORDS_DEF = 4096;

    localparam int ADDR_W      = 48;
    localparam int VA_W        = 64;
    localparam int WORD_W      = 64;
    localparam int IDX_W       = 12;
    localparam int CFG_IDX_W   = 8;
    localparam int STATUS_W    = 3;
    localparam int PERM_W      = 2;

    localparam int PAGE_SHIFT   = 12;
    localparam int ENTRY_IDX_W  = 9;
    localparam int L2_IDX_LSB   = 21;
    localparam int L3_IDX_LSB   = 12;
    localparam int L2_ALIGN_W   = 17;
    localparam int VA_TOP_LSB   = 30;
    localparam int ENTRY_BYTE_W = 3;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 104;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status STS_OK        = 3'd0;
    localparam t_status STS_UPPER     = 3'd1;
    localparam t_status STS_ABOVE_1G  = 3'd2;
    localparam t_status STS_MISALIGN  = 3'd3;
    localparam t_status STS_NOT_TABLE = 3'd4;
    localparam t_status STS_OUTSIDE   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_L2_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_BASE = 8'd1;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   pte_addr;
        logic [ADDR_W-1:0]   phys_addr;
        logic [PERM_W-1:0]   access_perm;
        logic                page_valid;
    } t_walk_res;

endpackage

[design/ptw_table_mem.sv]
`timescale 1ns / 1ps

module ptw_table_mem #(
    parameter int WINDOW_WORDS = ptw_pkg::WINDOW_WORDS_DEF,
    parameter int AW           = $clog2(WINDOW_WORDS)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ptw_pkg::WORD_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [ptw_pkg::WORD_W-1:0] o_rdata
);
    import ptw_pkg::*;

    logic [WORD_W-1:0] r_mem [WINDOW_WORDS];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/ptw_walk_ctrl.sv]
`timescale 1ns / 1ps

module ptw_walk_ctrl #(
    parameter int WINDOW_WORDS = ptw_pkg::WINDOW_WORDS_DEF,
    parameter int AW           = $clog2(WINDOW_WORDS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [ptw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ptw_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [ptw_pkg::VA_W-1:0]      i_virt_addr,
    input  logic [ptw_pkg::IDX_W-1:0]     i_word_index,
    input  logic [ptw_pkg::WORD_W-1:0]    i_word_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ptw_pkg::t_walk_res            o_res,
    output logic                          o_mem_we,
    output logic [AW-1:0]                 o_mem_waddr,
    output logic [ptw_pkg::WORD_W-1:0]    o_mem_wdata,
    output logic                          o_mem_re,
    output logic [AW-1:0]                 o_mem_raddr,
    input  logic [ptw_pkg::WORD_W-1:0]    i_mem_rdata
);
    import ptw_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_L2   = 2'd1;
    localparam logic [1:0] S_L3   = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    localparam logic [ADDR_W-1:0] WIN_BYTES = ADDR_W'(WINDOW_WORDS) << ENTRY_BYTE_W;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [ADDR_W-1:0]       r_l2_base;
    logic [ADDR_W-1:0]       r_win_base;
    logic [L2_IDX_LSB-1:0]   r_va_low;
    logic [ADDR_W-1:0]       r_pte_addr;
    logic                    r_out_valid;
    t_walk_res               r_out;
    t_walk_res               r_hold;

    logic                    w_acc;
    logic                    w_out_free;
    logic                    w_wr_ok;
    logic [ADDR_W-1:0]       w_l2_addr;
    logic [ADDR_W-1:0]       w_l3_addr;
    logic [ADDR_W-1:0]       w_off;
    logic                    w_inside;
    logic                    w_fin;
    t_walk_res               w_fin_res;
    logic                    w_load_out;

    assign w_acc      = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_wr_ok    = 32'(i_word_index) < 32'(WINDOW_WORDS);

    assign w_l2_addr = {r_l2_base[ADDR_W-1:PAGE_SHIFT],
                        i_virt_addr[L2_IDX_LSB +: ENTRY_IDX_W],
                        {ENTRY_BYTE_W{1'b0}}};
    assign w_l3_addr = {i_mem_rdata[ADDR_W-1:PAGE_SHIFT],
                        r_va_low[L3_IDX_LSB +: ENTRY_IDX_W],
                        {ENTRY_BYTE_W{1'b0}}};
    assign w_off     = ((r_state == S_L2) ? w_l3_addr : w_l2_addr) - r_win_base;
    assign w_inside  = w_off < WIN_BYTES;

    assign o_mem_waddr = AW'(i_word_index);
    assign o_mem_wdata = i_word_data;
    assign o_mem_raddr = w_off[ENTRY_BYTE_W +: AW];

    always_comb begin
        n_state   = r_state;
        w_fin     = 1'b0;
        w_fin_res = '0;
        o_mem_we  = 1'b0;
        o_mem_re  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (!i_cmd) begin
                        o_mem_we = w_wr_ok;
                    end else if (|i_virt_addr[ADDR_W-1:VA_TOP_LSB]) begin
                        w_fin            = 1'b1;
                        w_fin_res.status = STS_ABOVE_1G;
                    end else if (|i_virt_addr[VA_W-1:ADDR_W]) begin
                        w_fin            = 1'b1;
                        w_fin_res.status = STS_UPPER;
                    end else if (|r_l2_base[L2_ALIGN_W-1:0]) begin
                        w_fin            = 1'b1;
                        w_fin_res.status = STS_MISALIGN;
                    end else if (!w_inside) begin
                        w_fin            = 1'b1;
                        w_fin_res.status = STS_OUTSIDE;
                    end else begin
                        o_mem_re = 1'b1;
                        n_state  = S_L2;
                    end
                end
            end
            S_L2: begin
                if (i_mem_rdata[1:0] != 2'b11) begin
                    w_fin            = 1'b1;
                    w_fin_res.status = STS_NOT_TABLE;
                end else if (!w_inside) begin
                    w_fin            = 1'b1;
                    w_fin_res.status = STS_OUTSIDE;
                end else begin
                    o_mem_re = 1'b1;
                    n_state  = S_L3;
                end
            end
            S_L3: begin
                w_fin                 = 1'b1;
                w_fin_res.status      = STS_OK;
                w_fin_res.pte_addr    = r_pte_addr;
                w_fin_res.phys_addr   = {i_mem_rdata[ADDR_W-1:PAGE_SHIFT],
                                         r_va_low[PAGE_SHIFT-1:0]};
                w_fin_res.access_perm = i_mem_rdata[7:6];
                w_fin_res.page_valid  = i_mem_rdata[1:0] == 2'b11;
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_fin) begin
            n_state = w_out_free ? S_IDLE : S_HOLD;
        end
    end

    assign w_load_out = (w_fin || (r_state == S_HOLD)) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_l2_base   <= '0;
            r_win_base  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && (i_cfg_index == CFG_L2_BASE)) begin
                r_l2_base <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_WIN_BASE)) begin
                r_win_base <= i_cfg_data;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_fin ? w_fin_res : r_hold;
        end
        if (w_fin && !w_out_free) begin
            r_hold <= w_fin_res;
        end
        if (w_acc) begin
            r_va_low <= i_virt_addr[L2_IDX_LSB-1:0];
        end
        if (r_state == S_L2) begin
            r_pte_addr <= w_l3_addr;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

[design/two_level_page_table_walker_unit.sv]
`timescale 1ns / 1ps

// Two-level 4 KiB-granule page table walker over a local table window of
// WINDOW_WORDS 64-bit words, starting at window_base. A write word (tuser 0)
// fills one table word. A translate word (tuser 1) whose address or level two
// base fails the up-front checks, or whose level two entry falls outside the
// window, returns an error without a table read; otherwise the walk makes one
// or two dependent table reads (two for a full walk) and no new word is taken
// until it ends. Results sit in an output register, so the next word is taken
// while a result waits. The table memory is not cleared at reset: write every
// entry a walk can reach before translating through it. Configuration writes
// are always ready and are meant to be issued while the walker is idle.
module two_level_page_table_walker_unit #(
    parameter int WINDOW_WORDS = ptw_pkg::WINDOW_WORDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ptw_pkg::ADDR_W-1:0]       i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // virt_addr[63:0], word_index[75:64], word_data[139:76], zero pad
    input  logic [ptw_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // cmd[0]
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // pte_addr[47:0], phys_addr[95:48], access_perm[97:96], page_valid[98], zero pad
    output logic [ptw_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // status[2:0]
    output logic [ptw_pkg::STATUS_W-1:0]     o_m_axis_tuser
);
    import ptw_pkg::*;

    localparam int AW = $clog2(WINDOW_WORDS);

    logic [VA_W-1:0]   w_virt_addr;
    logic [IDX_W-1:0]  w_word_index;
    logic [WORD_W-1:0] w_word_data;
    t_walk_res         w_res;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [WORD_W-1:0] w_mem_wdata;
    logic              w_mem_re;
    logic [AW-1:0]     w_mem_raddr;
    logic [WORD_W-1:0] w_mem_rdata;

    assign w_virt_addr  = i_s_axis_tdata[VA_W-1:0];
    assign w_word_index = i_s_axis_tdata[VA_W +: IDX_W];
    assign w_word_data  = i_s_axis_tdata[VA_W+IDX_W +: WORD_W];

    assign o_cfg_ready = 1'b1;

    ptw_walk_ctrl #(
        .WINDOW_WORDS (WINDOW_WORDS),
        .AW           (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_cmd        (i_s_axis_tuser),
        .i_virt_addr  (w_virt_addr),
        .i_word_index (w_word_index),
        .i_word_data  (w_word_data),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_res        (w_res),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_re     (w_mem_re),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata)
    );

    ptw_table_mem #(
        .WINDOW_WORDS (WINDOW_WORDS),
        .AW           (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-2*ADDR_W-PERM_W-1){1'b0}},
                             w_res.page_valid, w_res.access_perm,
                             w_res.phys_addr, w_res.pte_addr};
    assign o_m_axis_tuser = w_res.status;

endmodule

[design/ptw_checker.sv]
`timescale 1ns / 1ps

module ptw_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    input  logic                             o_s_axis_tready,
    input  logic [ptw_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                             i_s_axis_tuser,
    input  logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic [ptw_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic [ptw_pkg::STATUS_W-1:0]     o_m_axis_tuser
);
    import ptw_pkg::*;

    logic w_in_acc;
    logic w_out_free;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !o_m_axis_tvalid || i_m_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != STS_OK) |-> (o_m_axis_tdata == '0))
        else $error("error result carries nonzero data");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_s_axis_tuser && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("table write produced a result");

    a_early_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_s_axis_tuser && (|i_s_axis_tdata[VA_W-1:VA_TOP_LSB]) && w_out_free
            |=> o_m_axis_tvalid && (o_m_axis_tuser != STS_OK))
        else $error("bad virtual address not reported in one cycle");

endmodule

bind two_level_page_table_walker_unit ptw_checker u_ptw_checker (.*);
